// File: hw/rtl/eiec_pkg.sv
`default_nettype none

package eiec_pkg;

    localparam int LINE_COUNT_DEF = 16;
    localparam int PIN_W          = 16;
    localparam int IRQ_W          = 7;
    localparam int PSEL_W         = 32;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;

    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_CLEAR   = 2'd1,
        OP_TRIGGER = 2'd2,
        OP_NOP     = 2'd3
    } t_eiec_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PORT_SELECT    = 3'd0,
        CFG_RISING_ENABLE  = 3'd1,
        CFG_FALLING_ENABLE = 3'd2,
        CFG_INTERRUPT_MASK = 3'd3,
        CFG_EVENT_MASK     = 3'd4
    } t_eiec_cfg_idx;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [PIN_W-1:0] pins_port_a;
        logic [PIN_W-1:0] pins_port_b;
        logic [PIN_W-1:0] pins_port_c;
        logic [PIN_W-1:0] pins_port_d;
        logic [PIN_W-1:0] write_data;
    } t_eiec_in;

    typedef struct packed {
        logic [PIN_W-1:0] pending_bits;
        logic [IRQ_W-1:0] irq_lines;
        logic [PIN_W-1:0] event_pulses;
    } t_eiec_out;

endpackage

`default_nettype wire

// File: hw/rtl/external_interrupt_edge_controller.sv
// Channel   Direction  Handshake                  Payload
// in        request in i_in_valid / o_in_ready    i_in_data  (t_eiec_in)
// out       result out o_out_valid / i_out_ready  o_out_data (t_eiec_out)
// cfg       write in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_wdata
//
// One request per clock while o_in_ready is high: edge detect, pending update and
// IRQ reduction sit in one combinational pass from the accepted request into the
// result register.
// A two-entry result buffer (result register plus skid) keeps accepting while one
// result waits; o_in_ready drops only when both entries are full.
// Reset is synchronous, active low, and clears configuration, line state and the
// result valid flags to zero.
`default_nettype none

module external_interrupt_edge_controller #(
    parameter int LINE_COUNT = eiec_pkg::LINE_COUNT_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  eiec_pkg::t_eiec_in                  i_in_data,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output eiec_pkg::t_eiec_out                 o_out_data,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [eiec_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [eiec_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import eiec_pkg::*;

    localparam logic [PIN_W-1:0] LineMask = PIN_W'((33'd1 << LINE_COUNT) - 33'd1);

    logic [PSEL_W-1:0] r_port_select;
    logic [PIN_W-1:0]  r_rise_en, r_fall_en, r_irq_mask, r_evt_mask;
    logic [PIN_W-1:0]  r_prev, r_pending, r_swtrig;
    logic [PIN_W-1:0]  n_prev, n_pending, n_swtrig;

    logic              r_main_vld, r_skid_vld;
    t_eiec_out         r_main, r_skid;
    t_eiec_out         n_res;

    logic [PIN_W-1:0]  levels, fired, data, active;
    logic [1:0]        psel;
    logic              in_acc, out_acc, cfg_acc;

    assign o_in_ready  = !r_skid_vld;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_main_vld;
    assign o_out_data  = r_main;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = r_main_vld && i_out_ready;
    assign cfg_acc = i_cfg_valid && o_cfg_ready;

    // line n follows pin n of the port picked by its select field
    always_comb begin
        levels = '0;
        for (int n = 0; n < PIN_W; n++) begin
            psel = r_port_select[2*n +: 2];
            case (psel)
                2'd0:    levels[n] = i_in_data.pins_port_a[n];
                2'd1:    levels[n] = i_in_data.pins_port_b[n];
                2'd2:    levels[n] = i_in_data.pins_port_c[n];
                default: levels[n] = i_in_data.pins_port_d[n];
            endcase
        end
        levels = levels & LineMask;
    end

    assign data = i_in_data.write_data & LineMask;

    always_comb begin
        fired     = '0;
        n_prev    = r_prev;
        n_pending = r_pending;
        n_swtrig  = r_swtrig;
        case (t_eiec_op'(i_in_data.opcode))
            OP_SAMPLE: begin
                fired = ((levels & ~r_prev & r_rise_en) | (~levels & r_prev & r_fall_en))
                        & LineMask;
                n_pending = r_pending | fired;
                n_prev    = levels;
            end
            OP_CLEAR: begin
                n_pending = r_pending & ~data;
                n_swtrig  = r_swtrig & ~data;
            end
            OP_TRIGGER: begin
                // only 0->1 transitions of the trigger register fire
                fired     = data & ~r_swtrig;
                n_swtrig  = r_swtrig | data;
                n_pending = r_pending | fired;
            end
            default: ;
        endcase
    end

    assign active = n_pending & r_irq_mask;

    always_comb begin
        n_res.pending_bits = n_pending;
        n_res.irq_lines    = {|active[15:10], |active[9:5], active[4:0]};
        n_res.event_pulses = fired & r_evt_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_select <= '0;
            r_rise_en     <= '0;
            r_fall_en     <= '0;
            r_irq_mask    <= '0;
            r_evt_mask    <= '0;
        end else if (cfg_acc) begin
            case (t_eiec_cfg_idx'(i_cfg_index))
                CFG_PORT_SELECT:    r_port_select <= i_cfg_wdata;
                CFG_RISING_ENABLE:  r_rise_en     <= i_cfg_wdata[PIN_W-1:0];
                CFG_FALLING_ENABLE: r_fall_en     <= i_cfg_wdata[PIN_W-1:0];
                CFG_INTERRUPT_MASK: r_irq_mask    <= i_cfg_wdata[PIN_W-1:0];
                CFG_EVENT_MASK:     r_evt_mask    <= i_cfg_wdata[PIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= '0;
            r_pending <= '0;
            r_swtrig  <= '0;
        end else if (in_acc) begin
            r_prev    <= n_prev;
            r_pending <= n_pending;
            r_swtrig  <= n_swtrig;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_acc) begin
            // a new request can only arrive here while the skid is empty
            r_main_vld <= r_skid_vld || in_acc;
            r_skid_vld <= 1'b0;
        end else if (in_acc) begin
            if (!r_main_vld) begin
                r_main_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_acc && r_skid_vld) begin
            r_main <= r_skid;
        end
        // skid is empty whenever a request is accepted
        if (in_acc) begin
            if (!r_main_vld || out_acc) begin
                r_main <= n_res;
            end else begin
                r_skid <= n_res;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/eiec_checker.sv
`default_nettype none

module eiec_checker (
    input wire                                 i_clk,
    input wire                                 i_rst_n,
    input wire                                 i_in_valid,
    input wire                                 o_in_ready,
    input wire                                 o_out_valid,
    input wire                                 i_out_ready,
    input eiec_pkg::t_eiec_out                 o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    a_accept_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted request produced no result");

    a_event_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.event_pulses & ~o_out_data.pending_bits) == '0)
        else $error("event pulse on a line that is not pending");

    a_irq_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_out_data.irq_lines[4:0] & ~o_out_data.pending_bits[4:0]) == '0) &&
            (!o_out_data.irq_lines[5] || (|o_out_data.pending_bits[9:5])) &&
            (!o_out_data.irq_lines[6] || (|o_out_data.pending_bits[15:10])))
        else $error("irq raised without a pending line");

endmodule

bind external_interrupt_edge_controller eiec_checker u_eiec_checker (.*);

`default_nettype wire
